### rtl/assert_macros.svh
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under synchronous reset
`define ASSERT_SAME(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error(msg);

// Next-cycle implication under synchronous reset
`define ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error(msg);

`endif

### rtl/mexp_pkg.sv
// Shared types and constants for the modular exponentiation block
`timescale 1ns / 1ps

package mexp_pkg;

  // Register word index (paddr[2]) of the modulus register
  localparam logic REG_MODULUS = 1'b0;

  // Request from the sequencer to the remainder unit
  typedef struct packed {
    logic start;  // latch dividend and begin
    logic wrap;   // modulus is zero: keep low bits only
  } red_ctrl_t;

  // Status back from the remainder unit
  typedef struct packed {
    logic busy;
    logic done;   // one-cycle pulse, remainder valid
  } red_stat_t;

endpackage

### rtl/mexp_reduce.sv
// Bit-serial remainder unit: 2*WIDTH-bit dividend mod WIDTH-bit modulus
`timescale 1ns / 1ps

module mexp_reduce #(
  parameter int WIDTH = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  mexp_pkg::red_ctrl_t    ctrl,
  input  logic [2*WIDTH-1:0]     dividend,
  input  logic [WIDTH-1:0]       modulus,
  output mexp_pkg::red_stat_t    stat,
  output logic [WIDTH-1:0]       remainder
);

  localparam int CW = $clog2(2 * WIDTH);

  logic [2*WIDTH-1:0] dvd;
  logic [WIDTH-1:0]   rem;
  logic [CW-1:0]      cnt;
  logic               busy;
  logic               done;

  logic [WIDTH:0]     trial;
  logic [WIDTH:0]     diff;
  logic               fits;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  assign trial = {rem, dvd[2*WIDTH-1]};
  assign diff  = trial - {1'b0, modulus};
  assign fits  = trial >= {1'b0, modulus};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (ctrl.start) begin
        if (ctrl.wrap) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy && cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      dvd <= dividend;
      cnt <= CW'(2 * WIDTH - 1);
      if (ctrl.wrap) begin
        rem <= dividend[WIDTH-1:0];
      end else begin
        rem <= '0;
      end
    end else if (busy) begin
      dvd <= {dvd[2*WIDTH-2:0], 1'b0};
      cnt <= cnt - 1'b1;
      rem <= fits ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign remainder = rem;

endmodule

### rtl/modular_exponentiation.sv
// Top level: right-to-left square and multiply modulo a configured modulus
//
//  channel   direction  handshake         payload
//  in        to block   in_valid/in_ready  base_value, power
//  out       from block out_valid/out_ready residue
//  apb       to block   psel/penable       paddr, pwdata, prdata (modulus)
//
// One multiplier and one bit-serial remainder unit are shared by all steps.
// Each modular step runs the remainder unit, one bit
// per cycle; an item takes (WIDTH + 1 + ones(power)) modular steps.
// A modulus of zero skips the bit-serial remainder unit in every
// step.
// rst is synchronous; it sets the modulus to 1 and empties the block.
// in_ready is high only while idle; the finished result is held in an output
// register, so a new item may start while the previous result waits.
`timescale 1ns / 1ps

module modular_exponentiation #(
  parameter int WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] base_value,
  input  logic [WIDTH-1:0] power,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] residue
);

  localparam int CW = $clog2(WIDTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_START = 3'd1;
  localparam logic [2:0] S_WAIT  = 3'd2;
  localparam logic [2:0] S_MUL   = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  // What the pending remainder belongs to
  localparam logic [1:0] T_BASE = 2'd0;
  localparam logic [1:0] T_ACC  = 2'd1;
  localparam logic [1:0] T_SQR  = 2'd2;

  logic [2:0]         state;
  logic [1:0]         target;
  logic [WIDTH-1:0]   modulus;
  logic [WIDTH-1:0]   bpow;
  logic [WIDTH-1:0]   acc;
  logic [WIDTH-1:0]   expo;
  logic [CW-1:0]      cnt;
  logic [2*WIDTH-1:0] prod;

  logic [WIDTH-1:0]   mul_a;
  logic [2*WIDTH-1:0] mul_out;
  logic               do_mul;

  mexp_pkg::red_ctrl_t red_ctrl;
  mexp_pkg::red_stat_t red_stat;
  logic [WIDTH-1:0]    red_rem;

  logic cfg_wr;
  logic in_acc;
  logic out_load;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == mexp_pkg::REG_MODULUS);
  assign prdata = (paddr[2] == mexp_pkg::REG_MODULUS) ? 32'(modulus) : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus <= WIDTH'(1);
    end else if (cfg_wr) begin
      modulus <= pwdata[WIDTH-1:0];
    end
  end

  // ---------------- shared arithmetic ----------------
  // Multiply step after a completed multiply is always a square
  assign do_mul  = (target != T_ACC) && expo[0];
  assign mul_a   = do_mul ? acc : bpow;
  assign mul_out = {{WIDTH{1'b0}}, mul_a} * {{WIDTH{1'b0}}, bpow};

  assign red_ctrl.start = (state == S_START);
  assign red_ctrl.wrap  = (modulus == '0);

  mexp_reduce #(
    .WIDTH(WIDTH)
  ) u_reduce (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (red_ctrl),
    .dividend  (prod),
    .modulus   (modulus),
    .stat      (red_stat),
    .remainder (red_rem)
  );

  // ---------------- sequencer ----------------
  assign in_ready = (state == S_IDLE) && !red_stat.busy;
  assign in_acc   = in_valid && in_ready;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_acc) begin
            state <= S_START;
          end
        end
        S_START: begin
          state <= S_WAIT;
        end
        S_WAIT: begin
          if (red_stat.done) begin
            if (target == T_SQR && cnt == CW'(WIDTH - 1)) begin
              state <= S_OUT;
            end else begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          state <= S_START;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      prod   <= {{WIDTH{1'b0}}, base_value};
      expo   <= power;
      acc    <= WIDTH'(1);
      cnt    <= '0;
      target <= T_BASE;
    end else if (state == S_MUL) begin
      prod   <= mul_out;
      target <= do_mul ? T_ACC : T_SQR;
    end else if (state == S_WAIT && red_stat.done) begin
      unique case (target)
        T_BASE: bpow <= red_rem;
        T_ACC:  acc  <= red_rem;
        T_SQR: begin
          bpow <= red_rem;
          expo <= expo >> 1;
          cnt  <= cnt + 1'b1;
        end
        default: acc <= red_rem;
      endcase
    end
  end

  // ---------------- output register ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      residue <= acc;
    end
  end

endmodule

### rtl/mexp_checker.sv
// Port-level checker for modular_exponentiation, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mexp_checker #(
  parameter int WIDTH = 16
) (
  input logic             clk,
  input logic             rst,
  input logic             psel,
  input logic             penable,
  input logic             pwrite,
  input logic [2:0]       paddr,
  input logic [31:0]      pwdata,
  input logic [31:0]      prdata,
  input logic             pready,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WIDTH-1:0] residue
);

  localparam logic [31:0] VMASK = 32'hFFFF_FFFF >> (32 - WIDTH);

  logic        mod_wr;
  logic        out_wait;
  logic [31:0] wr_value;
  logic        readback_ok;

  assign mod_wr      = psel && penable && pwrite && pready && (paddr[2] == mexp_pkg::REG_MODULUS);
  assign out_wait    = out_valid && !out_ready;
  assign readback_ok = (paddr[2] != mexp_pkg::REG_MODULUS) || (prdata == wr_value);

  // write data of the previous cycle, truncated to WIDTH bits
  always_ff @(posedge clk) begin
    wr_value <= pwdata & VMASK;
  end

  // Block works on one transaction at a time
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready, "ready after accept")

  // A waiting result is held
  `ASSERT_NEXT(a_out_hold, clk, rst, out_wait, out_valid && $stable(residue), "result dropped")

  // Modulus reads back what was written, truncated to WIDTH bits
  `ASSERT_NEXT(a_mod_readback, clk, rst, mod_wr, readback_ok, "modulus readback")

  // A non-existent register reads as zero
  `ASSERT_SAME(a_unmapped_zero, clk, rst, paddr[2], prdata == 32'd0, "unmapped read")

endmodule

bind modular_exponentiation mexp_checker #(.WIDTH(WIDTH)) u_mexp_checker (.*);

### verif/modular_exponentiation_test.sv
// Testbench for the modular exponentiation block: directed table, random phases, predictor
`timescale 1ns / 1ps

module modular_exponentiation_test;

  localparam int WIDTH = 16;
  localparam int RANDOM_ITEMS = 930;
  localparam int PHASES = 8;
  localparam int SETTLE_CYCLES = 40;
  localparam int STALL_LIMIT = 40000;

  typedef struct packed {
    logic [WIDTH-1:0] modulus;
    logic [WIDTH-1:0] base;
    logic [WIDTH-1:0] exponent;
    logic             known;
    logic [WIDTH-1:0] residue;
  } directed_row_t;

  typedef struct {
    logic [WIDTH-1:0] residue;
    int               item_no;
  } pending_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [2:0]       paddr = '0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [WIDTH-1:0] base_value = '0;
  logic [WIDTH-1:0] power = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [WIDTH-1:0] residue;

  pending_t         residue_queue[$];
  logic [WIDTH-1:0] modulus_copy = WIDTH'(1);
  logic [WIDTH-1:0] phase_moduli [PHASES];
  int               error_count = 0;
  int               item_count = 0;
  int               burst_left = 0;
  int               idle_cycles = 0;
  int               stall_left = 0;
  int               stretch_left = 0;
  logic             calm = 1'b1;

  // modulus, base, exponent, typed-in flag, residue
  directed_row_t directed_rows [25] = '{
    '{16'd1,     16'd5,      16'd0,      1'b1, 16'd1},
    '{16'd1,     16'hFFFF,   16'hFFFF,   1'b1, 16'd0},
    '{16'd1,     16'd0,      16'd0,      1'b1, 16'd1},
    '{16'd1,     16'd1234,   16'd1,      1'b1, 16'd0},
    '{16'hFFFF,  16'd0,      16'd0,      1'b1, 16'd1},
    '{16'hFFFF,  16'd0,      16'd1,      1'b1, 16'd0},
    '{16'hFFFF,  16'hFFFF,   16'hFFFF,   1'b1, 16'd0},
    '{16'hFFFF,  16'hFFFE,   16'd2,      1'b1, 16'd1},
    '{16'hFFFF,  16'hFFFE,   16'hFFFF,   1'b1, 16'hFFFE},
    '{16'hFFFF,  16'd2,      16'd16,     1'b1, 16'd1},
    '{16'hFFFF,  16'd1234,   16'hFFFF,   1'b0, 16'd0},
    '{16'hFFFF,  16'hAAAA,   16'h5555,   1'b0, 16'd0},
    '{16'd0,     16'd2,      16'd15,     1'b1, 16'h8000},
    '{16'd0,     16'd2,      16'd16,     1'b1, 16'd0},
    '{16'd0,     16'hFFFF,   16'hFFFF,   1'b1, 16'hFFFF},
    '{16'd0,     16'd3,      16'd0,      1'b1, 16'd1},
    '{16'd0,     16'h5555,   16'hAAAA,   1'b0, 16'd0},
    '{16'd0,     16'd0,      16'd0,      1'b1, 16'd1},
    '{16'd2,     16'hFFFF,   16'hFFFF,   1'b1, 16'd1},
    '{16'd2,     16'hFFFE,   16'd1,      1'b1, 16'd0},
    '{16'd65521, 16'hFFFF,   16'd65520,  1'b1, 16'd1},
    '{16'd65521, 16'd12345,  16'hFFFF,   1'b0, 16'd0},
    '{16'd7,     16'd7,      16'd5,      1'b1, 16'd0},
    '{16'd7,     16'hFFFF,   16'd3,      1'b1, 16'd1},
    '{16'd3,     16'd2,      16'h8000,   1'b0, 16'd0}
  };

  modular_exponentiation #(.WIDTH(WIDTH)) i_dut (
    .clk       (clk),
    .rst       (rst),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .base_value(base_value),
    .power     (power),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .residue   (residue)
  );

  always #4 clk = ~clk;

  // modulus zero stands for 2^WIDTH
  function automatic logic [2*WIDTH-1:0] reduce_mod(input logic [2*WIDTH-1:0] x,
                                                    input logic [WIDTH-1:0] m);
    if (m == '0) return {{WIDTH{1'b0}}, x[WIDTH-1:0]};
    return x % m;
  endfunction

  // right-to-left square and multiply, products kept at 2*WIDTH bits
  function automatic logic [WIDTH-1:0] mod_power(input logic [WIDTH-1:0] b,
                                                 input logic [WIDTH-1:0] e,
                                                 input logic [WIDTH-1:0] m);
    logic [2*WIDTH-1:0] square;
    logic [2*WIDTH-1:0] acc;
    square = reduce_mod({{WIDTH{1'b0}}, b}, m);
    acc = 1;
    for (int i = 0; i < WIDTH; i++) begin
      if (e[i]) acc = reduce_mod(acc * square, m);
      square = reduce_mod(square * square, m);
    end
    return acc[WIDTH-1:0];
  endfunction

  task automatic report_mismatch(input string what, input int item_no,
                                 input logic [WIDTH-1:0] want, input logic [WIDTH-1:0] got);
    $display("%0t: item %0d %s: expected %h, got %h", $time, item_no, what, want, got);
    error_count++;
  endtask

  task automatic send_item(input logic [WIDTH-1:0] b, input logic [WIDTH-1:0] e,
                           input logic known, input logic [WIDTH-1:0] typed);
    int gap;
    pending_t entry;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2000) : $urandom_range(1, 6);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    in_valid <= 1'b1;
    base_value <= b;
    power <= e;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    entry.residue = known ? typed : mod_power(b, e, modulus_copy);
    entry.item_no = item_count;
    residue_queue.push_back(entry);
    item_count++;
    burst_left--;
  endtask

  // stop sending and wait until every transaction has come back
  task automatic drain;
    if (in_valid) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    burst_left = 0;
    while (residue_queue.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_modulus(input logic [WIDTH-1:0] value);
    logic [31:0] word;
    drain();
    word = $urandom;  // upper bits are don't-care
    word[WIDTH-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {mexp_pkg::REG_MODULUS, 2'b00};
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    modulus_copy = value;
  endtask

  // result checking and receiver stall pattern
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (residue_queue.size() == 0) begin
          report_mismatch("residue with no transaction pending", -1, 'x, residue);
        end else begin
          if (residue !== residue_queue[0].residue)
            report_mismatch("residue", residue_queue[0].item_no, residue_queue[0].residue,
                            residue);
          void'(residue_queue.pop_front());
        end
      end
      if (stretch_left == 0) begin
        calm <= !calm;
        stretch_left <= $urandom_range(500, 8000);
      end else begin
        stretch_left <= stretch_left - 1;
      end
      if (stall_left > 0) begin
        out_ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else begin
        out_ready <= 1'b1;
        if (!calm) begin
          case ($urandom_range(0, 4999)) inside
            [1:100]: stall_left <= $urandom_range(1, 12);
            0:       stall_left <= $urandom_range(1000, 3000);
            default: ;
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles == STALL_LIMIT) begin
        $display("modular_exponentiation_test: errors");
        $finish;
      end
    end
  end

  initial begin
    logic [WIDTH-1:0] b;
    logic [WIDTH-1:0] e;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].modulus != modulus_copy) set_modulus(directed_rows[i].modulus);
      send_item(directed_rows[i].base, directed_rows[i].exponent, directed_rows[i].known,
                directed_rows[i].residue);
    end

    phase_moduli = '{16'hFFFF, 16'd0, WIDTH'($urandom_range(2, 65535)), 16'd1, 16'd65521,
                     WIDTH'($urandom_range(2, 255)), 16'd0,
                     WIDTH'($urandom_range(32768, 65535))};
    for (int p = 0; p < PHASES; p++) begin
      set_modulus(phase_moduli[p]);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        case ($urandom_range(0, 9))
          0:       b = '0;
          1:       b = WIDTH'(1);
          2:       b = '1;
          3:       b = modulus_copy - 1'b1;
          4:       b = modulus_copy + WIDTH'($urandom_range(0, 1));
          default: b = WIDTH'($urandom);
        endcase
        case ($urandom_range(0, 9))
          0:       e = '0;
          1:       e = WIDTH'($urandom_range(1, 3));
          2:       e = WIDTH'(1) << $urandom_range(0, WIDTH - 1);
          3:       e = '1;
          default: e = WIDTH'($urandom);
        endcase
        send_item(b, e, 1'b0, '0);
      end
    end

    drain();
    if (error_count == 0) begin
      $display("modular_exponentiation_test: clean");
    end else begin
      $display("modular_exponentiation_test: errors");
    end
    $finish;
  end

endmodule
